// File: design/attp_pkg.sv
// Shared types and constants of the asset tag TLV parser.
package attp_pkg;

  // Default width of the saturating value byte counter
  localparam int COUNT_WIDTH_DEF = 32;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Result payload width, padded to whole bytes
  localparam int OUT_BITS  = 1 + 3 + 4 * 64 + 64 + 32 + 1;
  localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  // Status codes
  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_SHORT       = 3'd1;
  localparam logic [2:0] ERR_TRUNC_LEN   = 3'd2;
  localparam logic [2:0] ERR_NONCANON    = 3'd3;
  localparam logic [2:0] ERR_LEN_MISMATCH = 3'd4;
  localparam logic [2:0] ERR_TYPE        = 3'd5;
  localparam logic [2:0] ERR_VALUE_SHORT = 3'd6;
  localparam logic [2:0] ERR_NULL_ID     = 3'd7;

  // Value byte positions
  localparam int ID_BYTES     = 32;
  localparam int AMOUNT_END   = 40;
  localparam int FLAGS_END    = 44;

  // Flag marker bytes that suppress the flags field
  localparam logic [7:0] MARKER_A = 8'h02;
  localparam logic [7:0] MARKER_B = 8'h03;

  // One classified beat handed from front to back
  typedef struct packed {
    logic [7:0] data;       // byte as received
    logic       store_en;   // byte lands in a field store
    logic [5:0] store_idx;  // value byte index, below 44 when store_en is set
    logic       last;       // final byte of the record
    logic [2:0] err;        // status found by the front, valid on last
    logic       len_ge44;   // declared length leaves room for flags
  } attp_beat_t;

endpackage

// File: design/attp_front.sv
// Front end: accepts record bytes, tracks the TLV header and classifies each byte.
module attp_front #(
  parameter int COUNT_WIDTH = attp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                q_full,
  output logic                q_push,
  output attp_pkg::attp_beat_t q_beat
);
  import attp_pkg::*;

  localparam logic [1:0] PH_TYPE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_FLAGS = COUNT_WIDTH'(FLAGS_END);

  logic [7:0]             type_code_r;
  logic [1:0]             phase_r, phase_nxt;
  logic [7:0]             rtype_r, rtype_nxt;
  logic [7:0]             header_r, header_nxt;
  logic [2:0]             seen_r, seen_nxt;
  logic [63:0]            decl_r, decl_nxt;
  logic [COUNT_WIDTH-1:0] vcount_r, vcount_nxt;
  logic                   fault_r, fault_nxt;
  logic [2:0]             last_seen;
  logic [63:0]            min_len;
  logic                   accept;
  logic [2:0]             err;
  logic                   store_en;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  // Length bytes and minimum value for an extended header
  always_comb begin
    case (header_r)
      8'd253: begin
        last_seen = 3'd1;
        min_len   = 64'd253;
      end
      8'd254: begin
        last_seen = 3'd3;
        min_len   = 64'h1_0000;
      end
      default: begin
        last_seen = 3'd7;
        min_len   = 64'h1_0000_0000;
      end
    endcase
  end

  // Advance the parse state by one byte
  always_comb begin
    phase_nxt  = phase_r;
    rtype_nxt  = rtype_r;
    header_nxt = header_r;
    seen_nxt   = seen_r;
    decl_nxt   = decl_r;
    vcount_nxt = vcount_r;
    fault_nxt  = fault_r;
    store_en   = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        header_nxt = in_tdata;
        if (in_tdata < 8'd253) begin
          decl_nxt  = 64'(in_tdata);
          phase_nxt = PH_VALUE;
        end else begin
          decl_nxt  = '0;
          seen_nxt  = '0;
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        decl_nxt[seen_r*8 +: 8] = in_tdata;
        seen_nxt = seen_r + 3'd1;
        if (seen_r == last_seen) begin
          if (decl_nxt < min_len) fault_nxt = 1'b1;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (!fault_r) begin
          store_en = (vcount_r < CNT_FLAGS);
          if (vcount_r != CNT_MAX) vcount_nxt = vcount_r + 1'b1;
        end
      end
      default: begin
        rtype_nxt = in_tdata;
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // Check the record in code order on the final byte
  always_comb begin
    if (phase_r == PH_TYPE)                   err = ERR_SHORT;
    else if (phase_nxt == PH_LENGTH)          err = ERR_TRUNC_LEN;
    else if (fault_nxt)                       err = ERR_NONCANON;
    else if (64'(vcount_nxt) != decl_nxt)     err = ERR_LEN_MISMATCH;
    else if (rtype_nxt != type_code_r)        err = ERR_TYPE;
    else if (decl_nxt < 64'(AMOUNT_END))      err = ERR_VALUE_SHORT;
    else                                      err = ERR_OK;
  end

  // Build the beat for the back end
  always_comb begin
    q_beat.data      = in_tdata;
    q_beat.store_en  = store_en;
    q_beat.store_idx = vcount_r[5:0];
    q_beat.last      = in_tlast;
    q_beat.err       = err;
    q_beat.len_ge44  = (decl_nxt >= 64'(FLAGS_END));
  end

  // Hold the type code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_code_r <= 8'd1;
    end else if (cfg_we) begin
      type_code_r <= cfg_wdata;
    end
  end

  // Update parse state, clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      rtype_r  <= '0;
      header_r <= '0;
      seen_r   <= '0;
      decl_r   <= '0;
      vcount_r <= '0;
      fault_r  <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        phase_r  <= PH_TYPE;
        rtype_r  <= '0;
        header_r <= '0;
        seen_r   <= '0;
        decl_r   <= '0;
        vcount_r <= '0;
        fault_r  <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        rtype_r  <= rtype_nxt;
        header_r <= header_nxt;
        seen_r   <= seen_nxt;
        decl_r   <= decl_nxt;
        vcount_r <= vcount_nxt;
        fault_r  <= fault_nxt;
      end
    end
  end

endmodule

// File: design/attp_fifo.sv
// Short beat queue between the front and back ends.
module attp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  attp_pkg::attp_beat_t push_beat,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output attp_pkg::attp_beat_t head_beat
);
  import attp_pkg::*;

  attp_beat_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;
  logic                  do_wr;
  logic                  do_rd;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_beat  = slot_r[rd_ptr_r];
  assign do_wr      = push && !full;
  assign do_rd      = pop && head_valid;

  // Store incoming beats
  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= push_beat;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/attp_back.sv
// Back end: collects the value fields and registers one result per record.
module attp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  attp_pkg::attp_beat_t          head_beat,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [attp_pkg::OUT_WIDTH-1:0] out_tdata
);
  import attp_pkg::*;

  logic [63:0]          id_r [4];
  logic [63:0]          id_nxt [4];
  logic [63:0]          amount_r, amount_nxt;
  logic [31:0]          flags_r, flags_nxt;
  logic                 marker_r, marker_nxt;
  logic                 out_valid_r;
  logic [OUT_WIDTH-1:0] out_data_r;
  logic [OUT_WIDTH-1:0] result;
  logic [2:0]           err;
  logic                 flags_ok;
  logic [5:0]           idx;
  logic [5:0]           amt_idx;
  logic [5:0]           flg_idx;

  assign pop        = head_valid && (!head_beat.last || !out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign idx        = head_beat.store_idx;
  assign amt_idx    = idx - 6'(ID_BYTES);
  assign flg_idx    = idx - 6'(AMOUNT_END);

  // Drop the byte into its field lane
  always_comb begin
    for (int k = 0; k < 4; k++) id_nxt[k] = id_r[k];
    amount_nxt = amount_r;
    flags_nxt  = flags_r;
    marker_nxt = marker_r;
    if (head_beat.store_en) begin
      if (idx < 6'(ID_BYTES)) begin
        id_nxt[idx[4:3]][idx[2:0]*8 +: 8] = head_beat.data;
      end else if (idx < 6'(AMOUNT_END)) begin
        amount_nxt[amt_idx[2:0]*8 +: 8] = head_beat.data;
      end else begin
        flags_nxt[flg_idx[1:0]*8 +: 8] = head_beat.data;
        if (idx == 6'(AMOUNT_END)) begin
          marker_nxt = (head_beat.data != MARKER_A) && (head_beat.data != MARKER_B);
        end
      end
    end
  end

  // Finish the status and pack the result
  always_comb begin
    err = head_beat.err;
    if (err == ERR_OK && (id_nxt[0] | id_nxt[1] | id_nxt[2] | id_nxt[3]) == 64'd0) begin
      err = ERR_NULL_ID;
    end
    flags_ok = head_beat.len_ge44 && marker_nxt;
    result = '0;
    result[3:1] = err;
    if (err == ERR_OK) begin
      result[0]       = 1'b1;
      result[67:4]    = id_nxt[0];
      result[131:68]  = id_nxt[1];
      result[195:132] = id_nxt[2];
      result[259:196] = id_nxt[3];
      result[323:260] = amount_nxt;
      result[355:324] = flags_ok ? flags_nxt : 32'd0;
      result[356]     = flags_ok;
    end
  end

  // Update field stores, clear them after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) id_r[k] <= '0;
      amount_r <= '0;
      flags_r  <= '0;
      marker_r <= 1'b0;
    end else if (pop) begin
      if (head_beat.last) begin
        for (int k = 0; k < 4; k++) id_r[k] <= '0;
        amount_r <= '0;
        flags_r  <= '0;
        marker_r <= 1'b0;
      end else begin
        for (int k = 0; k < 4; k++) id_r[k] <= id_nxt[k];
        amount_r <= amount_nxt;
        flags_r  <= flags_nxt;
        marker_r <= marker_nxt;
      end
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head_beat.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_beat.last) out_data_r <= result;
  end

endmodule

// File: design/asset_tag_tlv_parser_unit.sv
// Top level of the asset tag TLV parser: front end, beat queue and back end.
//
//  channel | direction | width | contents
//  in_     | sink      | 8     | tdata: data_byte; tlast: last_byte
//  out_    | source    | 360   | tdata: tag_valid, error_code, id words 0..3, amount,
//          |           |       |        flags, flags_present, zero pad
//  cfg_    | write     | 8     | asset_type_code
//
// One byte beat is taken every cycle while the queue has room; the front end updates
// its header state in that same cycle. After its last byte is taken, a result passes
// through the beat queue into the back end's output register. Reset is synchronous;
// there is no clearing pass. A stalled output holds the result while the four-beat
// queue keeps taking bytes; in_tready drops only when that queue is full.
module asset_tag_tlv_parser_unit #(
  parameter int COUNT_WIDTH = attp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] tag_valid, [3:1] error_code, [67:4] asset_id_word0, [131:68] asset_id_word1,
  // [195:132] asset_id_word2, [259:196] asset_id_word3, [323:260] asset_amount,
  // [355:324] asset_flags, [356] flags_present, [359:357] zero
  output logic [attp_pkg::OUT_WIDTH-1:0] out_tdata
);
  import attp_pkg::*;

  attp_beat_t push_beat;
  attp_beat_t head_beat;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;

  attp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_beat    (push_beat)
  );

  attp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_beat  (push_beat),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_beat  (head_beat)
  );

  attp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_beat  (head_beat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the asset tag TLV parser: record stimulus, parser model, scoreboard.
module testbench;
  import attp_pkg::*;

  // Compact-size header bytes that announce 2, 4 or 8 extended length bytes
  localparam int HDR_U16 = 253;
  localparam int HDR_U32 = 254;
  localparam int HDR_U64 = 255;
  localparam logic [63:0] COUNT_CAP = {64{1'b1}} >> (64 - COUNT_WIDTH_DEF);
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {P_TYPE, P_HEADER, P_LENGTH, P_VALUE} parse_phase_t;
  typedef enum {FILL_RANDOM, FILL_ZERO_ID, FILL_ONES, FILL_ZERO} fill_t;

  // Result beat as it sits on out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    logic        flags_present;
    logic [31:0] flags;
    logic [63:0] amount;
    logic [63:0] id3;
    logic [63:0] id2;
    logic [63:0] id1;
    logic [63:0] id0;
    logic [2:0]  err;
    logic        tag_ok;
  } tag_result_t;

  // One directed record: how to build it and, where obvious, its status
  typedef struct {
    bit          type_only;
    logic [7:0]  rtype;
    logic [7:0]  hdr;
    logic [63:0] ext_len;
    int          ext_sent;
    int          val_sent;
    fill_t       fill;
    int          marker;
    bit          typed;
    logic [2:0]  want_err;
  } rec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_WIDTH-1:0] out_tdata;

  asset_tag_tlv_parser_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // Parser model state
  parse_phase_t ps_phase;
  logic [7:0]  ps_type;
  logic [7:0]  ps_hdr;
  int          ps_len_seen;
  logic [63:0] ps_decl;
  logic [63:0] ps_count;
  logic [63:0] ps_id [4];
  logic [63:0] ps_amount;
  logic [31:0] ps_flags;
  bit          ps_marker_ok;
  bit          ps_len_bad;
  logic [7:0]  type_code;

  tag_result_t tag_expect_q [$];
  logic [7:0]  rec_q [$];
  rec_row_t    dir_plan [24];
  tag_result_t seen_r, want_r;
  int fail_count = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_tick = 0;
  int rx_mode = 0;
  int idle_cycles = 0;

  function automatic void clear_parser();
    ps_phase = P_TYPE;
    ps_type = '0;
    ps_hdr = '0;
    ps_len_seen = 0;
    ps_decl = '0;
    ps_count = '0;
    foreach (ps_id[k]) ps_id[k] = '0;
    ps_amount = '0;
    ps_flags = '0;
    ps_marker_ok = 1'b0;
    ps_len_bad = 1'b0;
  endfunction

  // Land one value byte in the id, amount or flags store
  function automatic void store_value_byte(input logic [7:0] b);
    logic [63:0] i;
    i = ps_count;
    if (i < ID_BYTES) begin
      ps_id[i[4:3]] |= 64'(b) << (i[2:0] * 8);
    end else if (i < AMOUNT_END) begin
      ps_amount |= 64'(b) << ((i - ID_BYTES) * 8);
    end else if (i < FLAGS_END) begin
      if (i == AMOUNT_END) ps_marker_ok = (b != MARKER_A && b != MARKER_B);
      ps_flags |= 32'(b) << ((i - AMOUNT_END) * 8);
    end
    if (ps_count < COUNT_CAP) ps_count++;
  endfunction

  // Advance the parser by one byte; a last byte yields the status beat
  function automatic void parse_byte(input logic [7:0] b, input bit last,
                                     output bit got, output tag_result_t r);
    logic [2:0] code;
    int need;
    logic [63:0] floor_len;
    bit fl;
    code = ERR_OK;
    got = 1'b0;
    r = '0;
    case (ps_phase)
      P_HEADER: begin
        ps_hdr = b;
        if (b < HDR_U16) begin
          ps_decl = 64'(b);
          ps_phase = P_VALUE;
        end else begin
          ps_decl = '0;
          ps_len_seen = 0;
          ps_phase = P_LENGTH;
        end
      end
      P_LENGTH: begin
        ps_decl |= 64'(b) << ((ps_len_seen & 7) * 8);
        ps_len_seen++;
        need = (ps_hdr == HDR_U16) ? 2 : (ps_hdr == HDR_U32) ? 4 : 8;
        floor_len = (ps_hdr == HDR_U16) ? 64'd253 :
                    (ps_hdr == HDR_U32) ? 64'h1_0000 : 64'h1_0000_0000;
        if (ps_len_seen >= need) begin
          if (ps_decl < floor_len) ps_len_bad = 1'b1;
          ps_phase = P_VALUE;
        end
      end
      P_VALUE: begin
        if (!ps_len_bad) store_value_byte(b);
      end
      default: begin
        ps_type = b;
        ps_phase = P_HEADER;
        if (last) code = ERR_SHORT;
      end
    endcase
    if (!last) return;
    // First failing check decides the status
    if (code == ERR_OK) begin
      if (ps_phase == P_LENGTH) code = ERR_TRUNC_LEN;
      else if (ps_len_bad) code = ERR_NONCANON;
      else if (ps_count != ps_decl) code = ERR_LEN_MISMATCH;
      else if (ps_type != type_code) code = ERR_TYPE;
      else if (ps_decl < AMOUNT_END) code = ERR_VALUE_SHORT;
      else if ((ps_id[0] | ps_id[1] | ps_id[2] | ps_id[3]) == '0) code = ERR_NULL_ID;
    end
    got = 1'b1;
    r.err = code;
    if (code == ERR_OK) begin
      fl = (ps_decl >= FLAGS_END) && ps_marker_ok;
      r.tag_ok = 1'b1;
      r.id0 = ps_id[0];
      r.id1 = ps_id[1];
      r.id2 = ps_id[2];
      r.id3 = ps_id[3];
      r.amount = ps_amount;
      r.flags = fl ? ps_flags : '0;
      r.flags_present = fl;
    end
    clear_parser();
  endfunction

  // Assemble the bytes of one record into rec_q
  function automatic void build_record(input bit type_only, input logic [7:0] rtype,
                                       input logic [7:0] hdr, input logic [63:0] ext_len,
                                       input int ext_sent, input int val_sent,
                                       input fill_t fill, input int marker);
    logic [7:0] v;
    rec_q.delete();
    rec_q.push_back(rtype);
    if (type_only) return;
    rec_q.push_back(hdr);
    for (int k = 0; k < ext_sent; k++) rec_q.push_back(ext_len[8*k +: 8]);
    for (int j = 0; j < val_sent; j++) begin
      case (fill)
        FILL_ZERO:    v = 8'h00;
        FILL_ONES:    v = 8'hFF;
        FILL_ZERO_ID: v = (j < ID_BYTES) ? 8'h00 : 8'($urandom);
        default:      v = 8'($urandom);
      endcase
      if (j == AMOUNT_END && marker >= 0) v = 8'(marker);
      rec_q.push_back(v);
    end
  endfunction

  // Mostly well-formed records with random content, the rest broken or noise
  task automatic make_random_record();
    int pick, n, m, need, mk;
    logic [7:0] h, t;
    logic [63:0] ext;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: mk = MARKER_A;
      1: mk = MARKER_B;
      default: mk = -1;
    endcase
    t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : type_code;
    if (pick < 60) begin
      if ($urandom_range(0, 19) == 0) begin
        n = HDR_U16 + int'($urandom_range(0, 6));
        build_record(1'b0, t, 8'(HDR_U16), 64'(n), 2, n, FILL_RANDOM, mk);
      end else begin
        n = $urandom_range(40, 64);
        build_record(1'b0, t, 8'(n), '0, 0, n,
                     ($urandom_range(0, 19) == 0) ? FILL_ZERO_ID : FILL_RANDOM, mk);
      end
    end else if (pick < 75) begin
      n = $urandom_range(0, 80);
      m = n + int'($urandom_range(0, 4)) - 2;
      if (m < 0) m = 0;
      build_record(1'b0, t, 8'(n), '0, 0, m, FILL_RANDOM, mk);
    end else if (pick < 88) begin
      h = 8'($urandom_range(HDR_U16, HDR_U64));
      need = (h == HDR_U16) ? 2 : (h == HDR_U32) ? 4 : 8;
      ext = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 300));
      build_record(1'b0, t, h, ext, $urandom_range(0, need), $urandom_range(0, 6),
                   FILL_RANDOM, mk);
    end else begin
      rec_q.delete();
      n = $urandom_range(1, 40);
      repeat (n) rec_q.push_back(8'($urandom));
    end
  endtask

  // Offer one beat in bursts with random gaps; predict on acceptance
  task automatic send_beat(input logic [7:0] b, input bit last, input bit typed,
                           input logic [2:0] want_err);
    int gap;
    bit got;
    tag_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    parse_byte(b, last, got, r);
    if (got) begin
      if (typed) begin
        r = '0;
        r.err = want_err;
      end
      tag_expect_q.push_back(r);
    end
  endtask

  task automatic send_record(input bit typed, input logic [2:0] want_err);
    foreach (rec_q[i]) send_beat(rec_q[i], i == rec_q.size() - 1, typed, want_err);
  endtask

  // Wait until every expected result beat has come back
  task automatic drain();
    do @(posedge clk); while (tag_expect_q.size() != 0);
  endtask

  task automatic set_type_code(input logic [7:0] v);
    in_tvalid <= 1'b0;
    drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    type_code = v;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %h got %h", $time, name, want, seen);
      fail_count++;
    end
  endfunction

  // Result monitor: compare each beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_r = out_tdata;
      if (tag_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %h", $time, out_tdata);
        fail_count++;
      end else begin
        want_r = tag_expect_q.pop_front();
        check_field("tag_valid", want_r.tag_ok, seen_r.tag_ok);
        check_field("error_code", want_r.err, seen_r.err);
        check_field("asset_id_word0", want_r.id0, seen_r.id0);
        check_field("asset_id_word1", want_r.id1, seen_r.id1);
        check_field("asset_id_word2", want_r.id2, seen_r.id2);
        check_field("asset_id_word3", want_r.id3, seen_r.id3);
        check_field("asset_amount", want_r.amount, seen_r.amount);
        check_field("asset_flags", want_r.flags, seen_r.flags);
        check_field("flags_present", want_r.flags_present, seen_r.flags_present);
      end
    end
  end

  // Receiver: switch stall pattern as rx_tick advances, honor long hold-off requests
  always @(posedge clk) begin
    if (hold_left == 0 && hold_asks != hold_served) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (rx_tick % 128 == 0) rx_mode = $urandom_range(0, 3);
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_tick % 4) != 0;
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [7:0] codes [6];
    int ph_bytes;
    bit paused;
    paused = 1'b0;
    codes = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'($urandom), 8'h80};
    // Directed records: status typed in where plain, else predicted
    dir_plan = '{
      '{1'b1, 8'h01, 8'd0, 64'd0, 0, 0, FILL_RANDOM, -1, 1'b1, ERR_SHORT},
      '{1'b0, 8'h01, 8'd253, 64'd0, 1, 0, FILL_RANDOM, -1, 1'b1, ERR_TRUNC_LEN},
      '{1'b0, 8'h01, 8'd255, 64'd0, 0, 0, FILL_RANDOM, -1, 1'b1, ERR_TRUNC_LEN},
      '{1'b0, 8'h01, 8'd253, 64'd252, 2, 5, FILL_RANDOM, -1, 1'b1, ERR_NONCANON},
      '{1'b0, 8'h01, 8'd254, 64'hFFFF, 4, 3, FILL_RANDOM, -1, 1'b1, ERR_NONCANON},
      '{1'b0, 8'h01, 8'd255, 64'hFFFF_FFFF, 8, 0, FILL_RANDOM, -1, 1'b1, ERR_NONCANON},
      '{1'b0, 8'h01, 8'd44, 64'd0, 0, 43, FILL_RANDOM, -1, 1'b1, ERR_LEN_MISMATCH},
      '{1'b0, 8'h01, 8'd40, 64'd0, 0, 41, FILL_RANDOM, -1, 1'b1, ERR_LEN_MISMATCH},
      '{1'b0, 8'h01, 8'd254, 64'h1_0000, 4, 10, FILL_RANDOM, -1, 1'b1, ERR_LEN_MISMATCH},
      '{1'b0, 8'h01, 8'd255, 64'h1_0000_0000, 8, 2, FILL_RANDOM, -1, 1'b1,
        ERR_LEN_MISMATCH},
      '{1'b0, 8'h01, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 8, 1, FILL_ONES, -1, 1'b1,
        ERR_LEN_MISMATCH},
      '{1'b0, 8'h02, 8'd40, 64'd0, 0, 40, FILL_RANDOM, -1, 1'b1, ERR_TYPE},
      '{1'b0, 8'hFF, 8'd44, 64'd0, 0, 44, FILL_ONES, -1, 1'b1, ERR_TYPE},
      '{1'b0, 8'h00, 8'd44, 64'd0, 0, 44, FILL_RANDOM, -1, 1'b1, ERR_TYPE},
      '{1'b0, 8'h01, 8'd39, 64'd0, 0, 39, FILL_RANDOM, -1, 1'b1, ERR_VALUE_SHORT},
      '{1'b0, 8'h01, 8'd0, 64'd0, 0, 0, FILL_RANDOM, -1, 1'b1, ERR_VALUE_SHORT},
      '{1'b0, 8'h01, 8'd40, 64'd0, 0, 40, FILL_ZERO_ID, -1, 1'b1, ERR_NULL_ID},
      '{1'b0, 8'h01, 8'd44, 64'd0, 0, 44, FILL_ZERO, -1, 1'b1, ERR_NULL_ID},
      '{1'b0, 8'h01, 8'd40, 64'd0, 0, 40, FILL_ONES, -1, 1'b0, ERR_OK},
      '{1'b0, 8'h01, 8'd44, 64'd0, 0, 44, FILL_RANDOM, int'(MARKER_A), 1'b0, ERR_OK},
      '{1'b0, 8'h01, 8'd44, 64'd0, 0, 44, FILL_RANDOM, int'(MARKER_B), 1'b0, ERR_OK},
      '{1'b0, 8'h01, 8'd44, 64'd0, 0, 44, FILL_ONES, 4, 1'b0, ERR_OK},
      '{1'b0, 8'h01, 8'd43, 64'd0, 0, 43, FILL_RANDOM, 0, 1'b0, ERR_OK},
      '{1'b0, 8'h01, 8'd253, 64'd253, 2, 253, FILL_RANDOM, -1, 1'b0, ERR_OK}
    };
    clear_parser();
    type_code = 8'h01;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table at the reset type code
    foreach (dir_plan[i]) begin
      build_record(dir_plan[i].type_only, dir_plan[i].rtype, dir_plan[i].hdr,
                   dir_plan[i].ext_len, dir_plan[i].ext_sent, dir_plan[i].val_sent,
                   dir_plan[i].fill, dir_plan[i].marker);
      send_record(dir_plan[i].typed, dir_plan[i].want_err);
    end

    // Random records, one phase per type code setting
    foreach (codes[p]) begin
      set_type_code(codes[p]);
      ph_bytes = bytes_sent;
      if (p == 1) hold_asks++;
      while (bytes_sent - ph_bytes < 30) begin
        if (p == 2 && !paused && bytes_sent - ph_bytes > 10) begin
          // Hold the sender until the pipeline is empty
          in_tvalid <= 1'b0;
          drain();
          paused = 1'b1;
        end
        make_random_record();
        send_record(1'b0, ERR_OK);
      end
    end

    in_tvalid <= 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && tag_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
design/attp_pkg.sv
design/attp_front.sv
design/attp_fifo.sv
design/attp_back.sv
design/asset_tag_tlv_parser_unit.sv
tb/testbench.sv
